// ===== rtl/assert_macros.svh =====
// Assertion helpers for the sorted integer set RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SIS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorted set assertion failed");

`define SIS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set assertion failed");

`else

`define SIS_ASSERT_ALWAYS(lbl, cond)
`define SIS_ASSERT_IMPLIES(lbl, ante, cons)

`endif

`endif

// ===== rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAME = 2'd2;

    localparam logic [VAL_W-1:0] EMPTY_MARK = '1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic search_rd;
        logic search_upd;
        logic find_rd;
        logic find_chk;
        logic decide;
        logic up_rd;
        logic up_wr;
        logic insert;
        logic dn_rd;
        logic dn_wr;
        logic dn_done;
        logic first_rd;
        logic last_rd;
        logic result_load;
    } sis_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic search_more;
        logic go_add;
        logic go_remove;
        logic up_more;
        logic dn_more;
        logic out_free;
    } sis_sts_t;

    // Signed ordering of two stored words
    function automatic logic key_less(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// ===== rtl/sis_if.sv =====
// ----------------------------------------------------------------------------
// sis_req_if / sis_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface sis_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sis_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [6:0]         count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               is_empty;
    logic [1:0]         status;

    modport source (output valid, output found, output count, output min_value,
                    output max_value, output is_empty, output status, input ready);
    modport sink   (input valid, input found, input count, input min_value,
                    input max_value, input is_empty, input status, output ready);
endinterface

// ===== rtl/sis_ctrl.sv =====
// ----------------------------------------------------------------------------
// sis_ctrl
// Sequencer: binary search, membership check, shift loop, end-point reads.
// ----------------------------------------------------------------------------
module sis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sis_pkg::sis_sts_t sts,
    output sis_pkg::sis_cmd_t cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SEARCH   = 14'b00000000000010,
        S_S_CMP    = 14'b00000000000100,
        S_FIND     = 14'b00000000001000,
        S_F_CMP    = 14'b00000000010000,
        S_DECIDE   = 14'b00000000100000,
        S_UP_CHK   = 14'b00000001000000,
        S_UP_WR    = 14'b00000010000000,
        S_INSERT   = 14'b00000100000000,
        S_DN_CHK   = 14'b00001000000000,
        S_DN_WR    = 14'b00010000000000,
        S_RD_FIRST = 14'b00100000000000,
        S_RD_LAST  = 14'b01000000000000,
        S_RESULT   = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.search_more)
                begin
                    cmd.search_rd = 1'b1;
                    state_next    = S_S_CMP;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_S_CMP:
            begin
                cmd.search_upd = 1'b1;
                state_next     = S_SEARCH;
            end
            S_FIND:
            begin
                cmd.find_rd = 1'b1;
                state_next  = S_F_CMP;
            end
            S_F_CMP:
            begin
                cmd.find_chk = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.go_add)
                    state_next = S_UP_CHK;
                else if (sts.go_remove)
                    state_next = S_DN_CHK;
                else
                    state_next = S_RD_FIRST;
            end
            S_UP_CHK:
            begin
                if (sts.up_more)
                begin
                    cmd.up_rd  = 1'b1;
                    state_next = S_UP_WR;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_UP_WR:
            begin
                cmd.up_wr  = 1'b1;
                state_next = S_UP_CHK;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_RD_FIRST;
            end
            S_DN_CHK:
            begin
                if (sts.dn_more)
                begin
                    cmd.dn_rd  = 1'b1;
                    state_next = S_DN_WR;
                end
                else
                begin
                    cmd.dn_done = 1'b1;
                    state_next  = S_RD_FIRST;
                end
            end
            S_DN_WR:
            begin
                cmd.dn_wr  = 1'b1;
                state_next = S_DN_CHK;
            end
            S_RD_FIRST:
            begin
                cmd.first_rd = 1'b1;
                state_next   = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                cmd.last_rd = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/sis_dp.sv =====
// ----------------------------------------------------------------------------
// sis_dp
// Entry store, search window, shift pointer, count and response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sis_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sis_pkg::sis_cmd_t          cmd,
    output sis_pkg::sis_sts_t          sts,
    input  logic [1:0]                 req_op,
    input  logic [sis_pkg::VAL_W-1:0]  req_value,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output logic                       rsp_found,
    output logic [sis_pkg::CNT_W-1:0]  rsp_count,
    output logic [sis_pkg::VAL_W-1:0]  rsp_min,
    output logic [sis_pkg::VAL_W-1:0]  rsp_max,
    output logic                       rsp_empty,
    output logic [1:0]                 rsp_status
);

    localparam logic [sis_pkg::CNT_W-1:0] CAP_CNT = sis_pkg::CNT_W'(sis_pkg::CAPACITY);

    logic [sis_pkg::VAL_W-1:0] mem [sis_pkg::CAPACITY];

    logic [1:0]                op_reg;
    logic [sis_pkg::VAL_W-1:0] value_reg;
    logic [sis_pkg::CNT_W-1:0] used_reg, used_next;
    logic [sis_pkg::CNT_W-1:0] lo_reg, lo_next;
    logic [sis_pkg::CNT_W-1:0] hi_reg, hi_next;
    logic [sis_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic                      found_reg;
    logic [1:0]                status_reg;
    logic [sis_pkg::VAL_W-1:0] rdata_reg;
    logic [sis_pkg::VAL_W-1:0] first_reg;
    logic                      rsp_valid_reg;

    logic [sis_pkg::CNT_W:0]   mid_sum;
    logic [sis_pkg::CNT_W-1:0] mid;
    logic [sis_pkg::CNT_W-1:0] ptr_dec;
    logic [sis_pkg::CNT_W-1:0] ptr_inc;
    logic [sis_pkg::CNT_W-1:0] used_dec;
    logic                      rd_en;
    logic [sis_pkg::IDX_W-1:0] rd_addr;
    logic                      wr_en;
    logic [sis_pkg::IDX_W-1:0] wr_addr;
    logic [sis_pkg::VAL_W-1:0] wr_data;
    logic                      is_full;
    logic                      set_empty;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[sis_pkg::CNT_W:1];
    assign ptr_dec  = ptr_reg - sis_pkg::CNT_W'(1);
    assign ptr_inc  = ptr_reg + sis_pkg::CNT_W'(1);
    assign used_dec = used_reg - sis_pkg::CNT_W'(1);
    assign is_full  = (used_reg >= CAP_CNT);
    assign set_empty = (used_reg == '0);

    // Status to the sequencer
    assign sts.search_more = (lo_reg < hi_reg);
    assign sts.go_add      = (op_reg == sis_pkg::OP_ADD) && !found_reg && !is_full;
    assign sts.go_remove   = (op_reg == sis_pkg::OP_REMOVE) && found_reg;
    assign sts.up_more     = (ptr_reg > lo_reg);
    assign sts.dn_more     = (ptr_inc < used_reg);
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    // Read port address
    always_comb
    begin
        rd_en   = cmd.search_rd | cmd.find_rd | cmd.up_rd | cmd.dn_rd
                | cmd.first_rd | cmd.last_rd;
        rd_addr = '0;
        if (cmd.search_rd)
            rd_addr = mid[sis_pkg::IDX_W-1:0];
        else if (cmd.find_rd)
            rd_addr = lo_reg[sis_pkg::IDX_W-1:0];
        else if (cmd.up_rd)
            rd_addr = ptr_dec[sis_pkg::IDX_W-1:0];
        else if (cmd.dn_rd)
            rd_addr = ptr_inc[sis_pkg::IDX_W-1:0];
        else if (cmd.last_rd)
            rd_addr = used_dec[sis_pkg::IDX_W-1:0];
    end

    // Write port: moved entry or inserted value
    always_comb
    begin
        wr_en   = cmd.up_wr | cmd.dn_wr | cmd.insert;
        wr_addr = ptr_reg[sis_pkg::IDX_W-1:0];
        wr_data = rdata_reg;
        if (cmd.insert)
        begin
            wr_addr = lo_reg[sis_pkg::IDX_W-1:0];
            wr_data = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Search window, pointer and count
    always_comb
    begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        ptr_next  = ptr_reg;
        used_next = used_reg;
        if (cmd.load)
        begin
            lo_next = '0;
            hi_next = used_reg;
        end
        if (cmd.search_upd)
        begin
            if (sis_pkg::key_less(rdata_reg, value_reg))
                lo_next = mid + sis_pkg::CNT_W'(1);
            else
                hi_next = mid;
        end
        if (cmd.decide)
        begin
            ptr_next = (op_reg == sis_pkg::OP_ADD) ? used_reg : lo_reg;
            if (op_reg == sis_pkg::OP_CLEAR)
                used_next = '0;
        end
        if (cmd.up_wr)
            ptr_next = ptr_dec;
        if (cmd.dn_wr)
            ptr_next = ptr_inc;
        if (cmd.insert)
            used_next = used_reg + sis_pkg::CNT_W'(1);
        if (cmd.dn_done)
            used_next = used_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            ptr_reg  <= ptr_next;
            if (cmd.result_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req_op;
            value_reg <= req_value;
        end
        if (cmd.find_chk)
            found_reg <= (lo_reg < used_reg) && (rdata_reg == value_reg);
        if (cmd.decide)
        begin
            status_reg <= sis_pkg::ST_DONE;
            if (op_reg == sis_pkg::OP_ADD)
            begin
                if (found_reg)
                    status_reg <= sis_pkg::ST_SAME;
                else if (is_full)
                    status_reg <= sis_pkg::ST_FULL;
            end
            else if (op_reg == sis_pkg::OP_REMOVE)
            begin
                if (!found_reg)
                    status_reg <= sis_pkg::ST_SAME;
            end
        end
        if (cmd.last_rd)
            first_reg <= rdata_reg;
        if (cmd.result_load)
        begin
            rsp_found  <= found_reg;
            rsp_count  <= used_reg;
            rsp_min    <= set_empty ? sis_pkg::EMPTY_MARK : first_reg;
            rsp_max    <= set_empty ? sis_pkg::EMPTY_MARK : rdata_reg;
            rsp_empty  <= set_empty;
            rsp_status <= status_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `SIS_ASSERT_ALWAYS(a_used_bound, used_reg <= CAP_CNT)
    `SIS_ASSERT_ALWAYS(a_window_order, lo_reg <= hi_reg)
    `SIS_ASSERT_IMPLIES(a_used_step, (used_reg != $past(used_reg)) && (used_reg != '0), (used_reg == $past(used_reg) + sis_pkg::CNT_W'(1)) || (used_reg == $past(used_reg) - sis_pkg::CNT_W'(1)))
    `SIS_ASSERT_IMPLIES(a_insert_room, cmd.insert, (lo_reg <= used_reg) && !is_full)

endmodule

// ===== rtl/sorted_integer_set_core.sv =====
// ----------------------------------------------------------------------------
// sorted_integer_set_core
// Ordered store of distinct signed 32-bit integers with add, remove, query
// and clear, one response word per request word.
// ----------------------------------------------------------------------------
//  channel  | dir | word fields
//  ---------+-----+---------------------------------------------------------
//  req      | in  | op[1:0], value[31:0] signed
//  rsp      | out | found, count[6:0], min_value, max_value, is_empty, status
//
//  Each word runs a binary search over the stored entries, one store read per
//  probe; an add then moves the entries above the insert point up by one and
//  a remove moves those above the removed entry down by one.
//  Reset: count and sequencer clear at once; the entry store is not cleared.
//  Hold a finished response in its own register and take the next request;
//  stall only when a second response is ready before the first is taken.
// ----------------------------------------------------------------------------
module sorted_integer_set_core (
    input  logic           clk,
    input  logic           rst_n,
    sis_req_if.sink        req,
    sis_rsp_if.source      rsp
);

    sis_pkg::sis_cmd_t cmd;
    sis_pkg::sis_sts_t sts;

    logic [sis_pkg::VAL_W-1:0] rsp_min;
    logic [sis_pkg::VAL_W-1:0] rsp_max;

    // Sequencer: owns the request handshake and steps the datapath
    sis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: entry store, search bounds, shift pointer, response register
    sis_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_op     (req.op),
        .req_value  (req.value),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .rsp_found  (rsp.found),
        .rsp_count  (rsp.count),
        .rsp_min    (rsp_min),
        .rsp_max    (rsp_max),
        .rsp_empty  (rsp.is_empty),
        .rsp_status (rsp.status)
    );

    // Present the end points as signed words
    assign rsp.min_value = $signed(rsp_min);
    assign rsp.max_value = $signed(rsp_max);

endmodule
